// ===== sv/assert_macros.svh =====
// Assertion macros shared by the string hash engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

// ===== sv/shash_pkg.sv =====
// Types, constants and helpers of the string hash engine.
`default_nettype none

package shash_pkg;

    // wyhash32 mixing constants, djb2 start value and reset seed
    localparam logic [31:0] WY_K0      = 32'h53c5ca59;
    localparam logic [31:0] WY_K1      = 32'h74743c1b;
    localparam logic [31:0] DJB_INIT   = 32'd5381;
    localparam logic [31:0] SEED_RESET = 32'd3913693727;

    // bytes carried by one input word
    localparam int BLOCK_BYTES = 8;

    // register map (word index within the configuration space)
    localparam logic REG_MODE = 1'b0;
    localparam logic REG_SEED = 1'b1;

    // mode codes
    localparam logic MODE_DJB = 1'b0;
    localparam logic MODE_WY  = 1'b1;

    // work handed from the front end to the back end
    typedef enum logic [1:0] {
        OP_NONE,
        OP_FULL,
        OP_TAIL,
        OP_ERROR
    } cmd_op_t;

    typedef struct packed {
        logic        mode;
        logic        init;
        cmd_op_t     op;
        logic [3:0]  nbytes;
        logic [31:0] seed;
        logic [31:0] len;
        logic [63:0] data;
    } cmd_t;

    typedef struct packed {
        logic [31:0] hash;
        logic        mismatch;
    } res_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_INIT,
        BK_BODY,
        BK_MIX,
        BK_DJB,
        BK_OUT
    } back_state_t;

    // pick byte idx of a little-endian word
    function automatic logic [7:0] byte_of(input logic [63:0] data, input logic [2:0] idx);
        byte_of = data[{idx, 3'b000} +: 8];
    endfunction

endpackage

`default_nettype wire

// ===== sv/shash_queue.sv =====
// Small register queue used between the engine's stages.
`default_nettype none

module shash_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // store the incoming word
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// ===== sv/shash_front.sv =====
// Front end: accepts input words, tracks message framing and issues work commands.
`default_nettype none

module shash_front
    import shash_pkg::*;
#(
    parameter int LENGTH_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        hash_mode,
    input  logic [31:0] hash_seed,
    input  logic        push,
    input  logic [63:0] block,
    input  logic [31:0] message_length,
    input  logic        first_block,
    input  logic        last_block,
    input  logic        cmd_full,
    output logic        cmd_push,
    output cmd_t        cmd
);

    localparam logic [LENGTH_BITS-1:0] WORD_BYTES = LENGTH_BITS'(BLOCK_BYTES);

    logic                   in_msg_reg, in_msg_next;
    logic                   mode_reg, mode_next;
    logic                   mis_reg, mis_next;
    logic [LENGTH_BITS-1:0] left_reg, left_next;

    logic                   accept;
    logic                   eff_open;
    logic                   eff_mis;
    logic [LENGTH_BITS-1:0] eff_left;
    logic                   init;
    cmd_op_t                op;

    // classify the word against the open message
    always_comb
    begin
        accept = push && !cmd_full;
        if (first_block)
        begin
            eff_open  = 1'b1;
            eff_mis   = 1'b0;
            eff_left  = message_length[LENGTH_BITS-1:0];
            mode_next = hash_mode;
        end
        else
        begin
            eff_open  = in_msg_reg;
            eff_mis   = mis_reg;
            eff_left  = left_reg;
            mode_next = mode_reg;
        end

        op          = OP_NONE;
        init        = first_block;
        in_msg_next = eff_open;
        left_next   = eff_left;
        mis_next    = eff_mis;

        if (!eff_open)
        begin
            if (last_block)
            begin
                op = OP_ERROR;
            end
        end
        else if (!last_block)
        begin
            if (eff_left > WORD_BYTES)
            begin
                op        = OP_FULL;
                left_next = eff_left - WORD_BYTES;
            end
            else
            begin
                mis_next = 1'b1;
            end
        end
        else
        begin
            in_msg_next = 1'b0;
            left_next   = '0;
            if ((eff_left > WORD_BYTES) || eff_mis)
            begin
                op   = OP_ERROR;
                init = 1'b0;
            end
            else
            begin
                op = OP_TAIL;
            end
        end

        cmd.mode   = mode_next;
        cmd.init   = init;
        cmd.op     = op;
        cmd.nbytes = eff_left[3:0];
        cmd.seed   = hash_seed;
        cmd.len    = 32'(eff_left);
        cmd.data   = block;
        cmd_push   = accept && ((op != OP_NONE) || init);
    end

    // hold framing state between words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_msg_reg <= 1'b0;
            mode_reg   <= MODE_DJB;
            mis_reg    <= 1'b0;
            left_reg   <= '0;
        end
        else if (accept)
        begin
            in_msg_reg <= in_msg_next;
            mode_reg   <= mode_next;
            mis_reg    <= mis_next;
            left_reg   <= left_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/shash_back.sv =====
// Back end: runs wyhash32 mixing on a shared multiplier, djb2 by shift and add, and emits results.
`default_nettype none

module shash_back
    import shash_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cmd_t cmd_in,
    input  logic cmd_empty,
    output logic cmd_pop,
    input  logic res_full,
    output logic res_push,
    output res_t res
);

    back_state_t state_reg, state_next;
    cmd_t        cmd_reg, cmd_next;
    logic [31:0] mix_a_reg, mix_a_next;
    logic [31:0] mix_b_reg, mix_b_next;
    logic [1:0]  mix_left_reg, mix_left_next;
    logic        body_done_reg, body_done_next;
    logic [3:0]  byte_idx_reg, byte_idx_next;

    logic [31:0] opa;
    logic [31:0] opb;
    logic [63:0] product;
    logic [3:0]  byte_count;
    logic [2:0]  tail_shift;
    logic [3:0]  tail_last;
    logic [7:0]  djb_byte;

    // shared 32x32 mixer
    assign opa        = mix_a_reg ^ WY_K0;
    assign opb        = mix_b_reg ^ WY_K1;
    assign product    = opa * opb;
    assign byte_count = (cmd_reg.op == OP_FULL) ? 4'(BLOCK_BYTES) : cmd_reg.nbytes;
    assign tail_shift = 3'(cmd_reg.nbytes - 4'd4);
    assign tail_last  = cmd_reg.nbytes - 4'd1;
    assign djb_byte   = byte_of(cmd_reg.data, byte_idx_reg[2:0]);

    // sequence the steps of one command
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!cmd_empty)
                begin
                    if (cmd_in.op == OP_ERROR)
                    begin
                        state_next = BK_OUT;
                    end
                    else if (cmd_in.init)
                    begin
                        state_next = BK_INIT;
                    end
                    else
                    begin
                        state_next = BK_BODY;
                    end
                end
            end
            BK_INIT:
            begin
                state_next = (cmd_reg.mode == MODE_WY) ? BK_MIX : BK_BODY;
            end
            BK_BODY:
            begin
                if (cmd_reg.op == OP_NONE)
                begin
                    state_next = BK_IDLE;
                end
                else if (cmd_reg.mode == MODE_WY)
                begin
                    state_next = BK_MIX;
                end
                else
                begin
                    state_next = BK_DJB;
                end
            end
            BK_MIX:
            begin
                if (mix_left_reg == 2'd1)
                begin
                    if (!body_done_reg)
                    begin
                        state_next = BK_BODY;
                    end
                    else
                    begin
                        state_next = (cmd_reg.op == OP_TAIL) ? BK_OUT : BK_IDLE;
                    end
                end
            end
            BK_DJB:
            begin
                if (byte_idx_reg == byte_count)
                begin
                    state_next = (cmd_reg.op == OP_TAIL) ? BK_OUT : BK_IDLE;
                end
            end
            BK_OUT:
            begin
                if (!res_full)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // datapath updates and handshakes
    always_comb
    begin
        cmd_next       = cmd_reg;
        mix_a_next     = mix_a_reg;
        mix_b_next     = mix_b_reg;
        mix_left_next  = mix_left_reg;
        body_done_next = body_done_reg;
        byte_idx_next  = byte_idx_reg;
        cmd_pop        = 1'b0;
        res_push       = 1'b0;
        res.mismatch   = (cmd_reg.op == OP_ERROR);
        if (cmd_reg.op == OP_ERROR)
        begin
            res.hash = '0;
        end
        else if (cmd_reg.mode == MODE_WY)
        begin
            res.hash = mix_a_reg ^ mix_b_reg;
        end
        else
        begin
            res.hash = mix_a_reg;
        end

        case (state_reg)
            BK_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop  = 1'b1;
                    cmd_next = cmd_in;
                end
            end
            BK_INIT:
            begin
                body_done_next = 1'b0;
                mix_left_next  = 2'd1;
                if (cmd_reg.mode == MODE_WY)
                begin
                    mix_a_next = cmd_reg.seed;
                    mix_b_next = cmd_reg.len;
                end
                else
                begin
                    mix_a_next = DJB_INIT;
                    mix_b_next = '0;
                end
            end
            BK_BODY:
            begin
                body_done_next = 1'b1;
                byte_idx_next  = '0;
                if (cmd_reg.mode == MODE_WY)
                begin
                    if (cmd_reg.op == OP_FULL)
                    begin
                        mix_a_next    = mix_a_reg ^ cmd_reg.data[31:0];
                        mix_b_next    = mix_b_reg ^ cmd_reg.data[63:32];
                        mix_left_next = 2'd1;
                    end
                    else
                    begin
                        mix_left_next = 2'd2;
                        if (cmd_reg.nbytes >= 4'd4)
                        begin
                            mix_a_next = mix_a_reg ^ cmd_reg.data[31:0];
                            mix_b_next = mix_b_reg
                                       ^ cmd_reg.data[{tail_shift, 3'b000} +: 32];
                        end
                        else if (cmd_reg.nbytes != 4'd0)
                        begin
                            mix_a_next = mix_a_reg
                                       ^ {8'd0,
                                          byte_of(cmd_reg.data, 3'd0),
                                          byte_of(cmd_reg.data, {1'b0, cmd_reg.nbytes[2:1]}),
                                          byte_of(cmd_reg.data, tail_last[2:0])};
                        end
                    end
                end
            end
            BK_MIX:
            begin
                mix_a_next    = product[31:0];
                mix_b_next    = product[63:32];
                mix_left_next = mix_left_reg - 2'd1;
            end
            BK_DJB:
            begin
                if (byte_idx_reg != byte_count)
                begin
                    mix_a_next    = (mix_a_reg << 5) + mix_a_reg + 32'(djb_byte);
                    byte_idx_next = byte_idx_reg + 4'd1;
                end
            end
            BK_OUT:
            begin
                res_push = !res_full;
            end
            default:
            begin
                cmd_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        mix_a_reg     <= mix_a_next;
        mix_b_reg     <= mix_b_next;
        mix_left_reg  <= mix_left_next;
        body_done_reg <= body_done_next;
        byte_idx_reg  <= byte_idx_next;
    end

endmodule

`default_nettype wire

// ===== sv/string_hash_engine_core.sv =====
// Top level of the string hash engine: register port, front end, command queue, back end.
// wyhash32: each full word is folded in and mixed on the shared 32x32 mixer, the first word
// adds a premix of seed and length, the last word a final mix before the result write.
// djb2: one byte per cycle through the multiply-by-33 step.
// A result also waits behind any commands still queued ahead of its last word.
// Reset (asynchronous, active low) clears framing, queues and sequencer; no clearing pass.
`default_nettype none

`include "assert_macros.svh"

module string_hash_engine_core
    import shash_pkg::*;
#(
    parameter int LENGTH_BITS = 32,
    parameter int CMD_DEPTH   = 2,
    parameter int RES_DEPTH   = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  logic [63:0] block,
    input  logic [31:0] message_length,
    input  logic        first_block,
    input  logic        last_block,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] hash_value,
    output logic        length_mismatch
);

    logic        hash_mode_reg;
    logic [31:0] hash_seed_reg;
    logic        cfg_write;

    cmd_t        cmd_wr;
    cmd_t        cmd_rd;
    logic        cmd_push;
    logic        cmd_full;
    logic        cmd_pop;
    logic        cmd_empty;
    res_t        res_wr;
    res_t        res_rd;
    logic        res_push;
    logic        res_full;

    // configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_SEED) ? hash_seed_reg : {31'd0, hash_mode_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_mode_reg <= MODE_WY;
            hash_seed_reg <= SEED_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_MODE)
            begin
                hash_mode_reg <= pwdata[0];
            end
            else
            begin
                hash_seed_reg <= pwdata;
            end
        end
    end

    assign full = cmd_full;

    shash_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .hash_mode      (hash_mode_reg),
        .hash_seed      (hash_seed_reg),
        .push           (push),
        .block          (block),
        .message_length (message_length),
        .first_block    (first_block),
        .last_block     (last_block),
        .cmd_full       (cmd_full),
        .cmd_push       (cmd_push),
        .cmd            (cmd_wr)
    );

    shash_queue #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd_wr),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .rdata (cmd_rd),
        .empty (cmd_empty)
    );

    shash_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_in    (cmd_rd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_wr)
    );

    shash_queue #(
        .WIDTH ($bits(res_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_wr),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rd),
        .empty (empty)
    );

    assign hash_value      = res_rd.hash;
    assign length_mismatch = res_rd.mismatch;

    // sanity checks on the internal handshakes
    `ASSERT_NEVER(a_cmd_overrun, cmd_push && cmd_full, "command written into a full queue")
    `ASSERT_NEVER(a_res_overrun, res_push && res_full, "result written into a full queue")
    `ASSERT_PROP(a_res_source, $fell(empty) |-> $past(res_push), "result appeared unpushed")
    `ASSERT_PROP(a_err_zero, (res_push && res_wr.mismatch) |-> (res_wr.hash == '0),
                 "mismatch result carries a nonzero hash")

endmodule

`default_nettype wire
